// File: hw/rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared constants, types and the CRC byte step for the byte-stuffed
// frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

	localparam int MAX_PAYLOAD_BYTES = 32;
	localparam int HEADER_LEN        = 6;
	localparam int MIN_FRAME_LEN     = 8;
	localparam int STORE_DEPTH       = MIN_FRAME_LEN + MAX_PAYLOAD_BYTES;
	localparam int ADDR_W            = $clog2(STORE_DEPTH);
	localparam int FILL_W            = $clog2(STORE_DEPTH + 1);
	localparam int HDR_IDX_W         = $clog2(HEADER_LEN);

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;

	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
	localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRC_RD,
		ST_CRC_UPD,
		ST_CRC_CHK,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // line byte accepted this cycle
		logic start_crc;   // frame passed size checks, start CRC pass
		logic crc_step;    // fold RAM read data into CRC, advance counter
		logic start_emit;  // CRC matched, start result pass
		logic emit_step;   // result taken, advance to next payload byte
		logic sel_payload; // RAM read address points into payload
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_flag;
		logic frame_ok;
		logic crc_last;
		logic crc_match;
		logic emit_last;
	} sts_t;

	// MSB-first, unreflected CRC-16 over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] data, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Byte-stuffed frame receiver with CRC-16 check and per-byte result items.
// ----------------------------------------------------------------------------
// Line byte intake: one item per cycle while no frame is being closed.
// At an accepted closing flag: a CRC pass over the header and payload bytes
// (one store RAM port, each byte read then folded), a compare, then a result
// pass with a RAM read and then a presentation per result item. Intake stalls
// until the last result is taken or the compare fails. Reset clears controller,
// fill count, pass counter and escape state and sets config registers to their
// reset values; the frame store holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	// line byte items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     line_byte,
	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     source_addr,
	output logic [7:0]                     dest_addr,
	output logic [7:0]                     frame_kind,
	output logic [7:0]                     data_kind,
	output logic [7:0]                     sequence_no,
	output logic [5:0]                     payload_length,
	output logic [15:0]                    received_crc,
	output logic [7:0]                     payload_byte,
	output logic [4:0]                     payload_index,
	output logic                           has_payload,
	output logic                           last_of_frame
);

	bsfr_pkg::cmd_t cmd;
	bsfr_pkg::sts_t sts;

	// sequencer: intake, CRC pass, result pass
	bsfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// unstuffing, store, CRC and result fields
	bsfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.line_byte     (line_byte),
		.source_addr   (source_addr),
		.dest_addr     (dest_addr),
		.frame_kind    (frame_kind),
		.data_kind     (data_kind),
		.sequence_no   (sequence_no),
		.payload_length(payload_length),
		.received_crc  (received_crc),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.has_payload   (has_payload),
		.last_of_frame (last_of_frame)
	);

	// intake and result presentation never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("result presented while intake open");

	// intake only closes after a flag byte was taken
	a_close_on_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && line_byte == bsfr_pkg::FLAG_BYTE))
		else $error("intake closed without a flag");

	// taking the last result of a frame reopens intake
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_frame |=> in_ready && !out_valid)
		else $error("intake not reopened after last result");

endmodule

// File: hw/rtl/bsfr_ram.sv
// ----------------------------------------------------------------------------
// bsfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/bsfr_dp.sv
// ----------------------------------------------------------------------------
// bsfr_dp
// Datapath: unstuffing, frame store, header and trailer capture,
// CRC accumulation, config registers and result fields.
// ----------------------------------------------------------------------------
module bsfr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsfr_pkg::cmd_t                 cmd,
	output bsfr_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic [7:0]                     line_byte,
	output logic [7:0]                     source_addr,
	output logic [7:0]                     dest_addr,
	output logic [7:0]                     frame_kind,
	output logic [7:0]                     data_kind,
	output logic [7:0]                     sequence_no,
	output logic [5:0]                     payload_length,
	output logic [15:0]                    received_crc,
	output logic [7:0]                     payload_byte,
	output logic [4:0]                     payload_index,
	output logic                           has_payload,
	output logic                           last_of_frame
);

	logic [15:0] poly_q;
	logic [15:0] init_q;
	logic [15:0] crc_q;

	logic [bsfr_pkg::FILL_W-1:0] fill_q;
	logic [bsfr_pkg::FILL_W-1:0] cnt_q;
	logic                        esc_q;

	logic [7:0] hdr_q [bsfr_pkg::HEADER_LEN];
	logic [7:0] tail_prev_q;
	logic [7:0] tail_last_q;

	logic [7:0] len;
	logic       is_flag;
	logic       is_esc;
	logic       store_req;
	logic       store_en;
	logic [7:0] store_val;

	logic [bsfr_pkg::ADDR_W-1:0] raddr;
	logic [7:0]                  rdata;

	assign len     = hdr_q[5];
	assign is_flag = (line_byte == bsfr_pkg::FLAG_BYTE);
	assign is_esc  = (line_byte == bsfr_pkg::ESC_BYTE);

	always_comb begin
		store_req = 1'b0;
		store_val = line_byte;
		if (cmd.take && !is_flag) begin
			if (esc_q) begin
				store_req = 1'b1;
				store_val = line_byte ^ bsfr_pkg::ESC_XOR;
			end else if (!is_esc) begin
				store_req = 1'b1;
			end
		end
	end

	assign store_en = store_req &&
		(fill_q < bsfr_pkg::FILL_W'(bsfr_pkg::STORE_DEPTH));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= bsfr_pkg::CRC_POLY_RESET;
			init_q <= bsfr_pkg::CRC_INIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bsfr_pkg::REG_CRC_POLY) begin
				poly_q <= cfg_data;
			end else if (cfg_index == bsfr_pkg::REG_CRC_INIT) begin
				init_q <= cfg_data;
			end
		end
	end

	// receive side control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			esc_q  <= 1'b0;
		end else if (cmd.take) begin
			if (is_flag) begin
				fill_q <= '0;
				esc_q  <= 1'b0;
			end else if (esc_q) begin
				esc_q <= 1'b0;
				fill_q <= store_en ? fill_q + 1'b1 : '0;
			end else if (is_esc) begin
				esc_q <= 1'b1;
			end else begin
				fill_q <= store_en ? fill_q + 1'b1 : '0;
			end
		end
	end

	// header and trailer capture
	always_ff @(posedge clk) begin
		if (store_en) begin
			if (fill_q < bsfr_pkg::FILL_W'(bsfr_pkg::HEADER_LEN)) begin
				hdr_q[fill_q[bsfr_pkg::HDR_IDX_W-1:0]] <= store_val;
			end
			tail_prev_q <= tail_last_q;
			tail_last_q <= store_val;
		end
	end

	// pass counter and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_crc || cmd.start_emit) begin
			cnt_q <= '0;
		end else if (cmd.crc_step || cmd.emit_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_crc) begin
			crc_q <= init_q;
		end else if (cmd.crc_step) begin
			crc_q <= bsfr_pkg::crc_byte(crc_q, rdata, poly_q);
		end
	end

	assign raddr = cmd.sel_payload ?
		bsfr_pkg::ADDR_W'(bsfr_pkg::HEADER_LEN) + cnt_q[bsfr_pkg::ADDR_W-1:0] :
		cnt_q[bsfr_pkg::ADDR_W-1:0];

	bsfr_ram #(
		.WIDTH(8),
		.DEPTH(bsfr_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_en),
		.waddr(fill_q[bsfr_pkg::ADDR_W-1:0]),
		.wdata(store_val),
		.raddr(raddr),
		.rdata(rdata)
	);

	// status
	assign sts.is_flag   = is_flag;
	assign sts.frame_ok  = (fill_q >= bsfr_pkg::FILL_W'(bsfr_pkg::MIN_FRAME_LEN)) &&
		(len <= 8'(bsfr_pkg::MAX_PAYLOAD_BYTES)) &&
		(9'(fill_q) == 9'(len) + 9'(bsfr_pkg::MIN_FRAME_LEN));
	assign sts.crc_last  = (9'(cnt_q) + 9'd1) == (9'(len) + 9'(bsfr_pkg::HEADER_LEN));
	assign sts.crc_match = (crc_q == {tail_prev_q, tail_last_q});
	assign sts.emit_last = (9'(cnt_q) + 9'd1) >= 9'(len);

	// result fields
	assign source_addr    = hdr_q[0];
	assign dest_addr      = hdr_q[1];
	assign frame_kind     = hdr_q[2];
	assign data_kind      = hdr_q[3];
	assign sequence_no    = hdr_q[4];
	assign payload_length = len[5:0];
	assign received_crc   = {tail_prev_q, tail_last_q};
	assign has_payload    = (len != 8'd0);
	assign payload_byte   = has_payload ? rdata : 8'd0;
	assign payload_index  = has_payload ? 5'(cnt_q) : 5'd0;
	assign last_of_frame  = sts.emit_last;

endmodule

// File: hw/rtl/bsfr_ctrl.sv
// ----------------------------------------------------------------------------
// bsfr_ctrl
// Controller: sequences byte intake, the CRC pass over the store and
// the result pass.
// ----------------------------------------------------------------------------
module bsfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  bsfr_pkg::sts_t sts,
	output bsfr_pkg::cmd_t cmd
);

	bsfr_pkg::ctrl_state_t state_q;
	bsfr_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsfr_pkg::ST_IDLE: begin
				if (in_valid && sts.is_flag && sts.frame_ok) begin
					state_d = bsfr_pkg::ST_CRC_RD;
				end
			end
			bsfr_pkg::ST_CRC_RD: begin
				state_d = bsfr_pkg::ST_CRC_UPD;
			end
			bsfr_pkg::ST_CRC_UPD: begin
				state_d = sts.crc_last ? bsfr_pkg::ST_CRC_CHK : bsfr_pkg::ST_CRC_RD;
			end
			bsfr_pkg::ST_CRC_CHK: begin
				state_d = sts.crc_match ? bsfr_pkg::ST_EMIT_RD : bsfr_pkg::ST_IDLE;
			end
			bsfr_pkg::ST_EMIT_RD: begin
				state_d = bsfr_pkg::ST_EMIT_OUT;
			end
			bsfr_pkg::ST_EMIT_OUT: begin
				if (out_ready) begin
					state_d = sts.emit_last ? bsfr_pkg::ST_IDLE : bsfr_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = bsfr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		out_valid       = 1'b0;
		cmd             = '0;
		unique case (state_q)
			bsfr_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.take      = in_valid;
				cmd.start_crc = in_valid && sts.is_flag && sts.frame_ok;
			end
			bsfr_pkg::ST_CRC_RD: begin
			end
			bsfr_pkg::ST_CRC_UPD: begin
				cmd.crc_step = 1'b1;
			end
			bsfr_pkg::ST_CRC_CHK: begin
				cmd.start_emit = sts.crc_match;
			end
			bsfr_pkg::ST_EMIT_RD: begin
				cmd.sel_payload = 1'b1;
			end
			bsfr_pkg::ST_EMIT_OUT: begin
				cmd.sel_payload = 1'b1;
				out_valid       = 1'b1;
				cmd.emit_step   = out_ready && !sts.emit_last;
			end
			default: begin
			end
		endcase
	end

endmodule
